// ===== src/bdq_pkg.sv =====
// Shared types and operation codes for the bounded deque with extract.
// No dependencies; bdq_cell, the top level and bdq_checker import this package.
`default_nettype none
package bdq_pkg;

   localparam int FUNC_WIDTH = 3;
   localparam int DATA_WIDTH = 32;
   localparam int LIMIT_WIDTH = 7;

   localparam logic [FUNC_WIDTH-1:0] FUNC_APPEND       = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE_FRONT = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE_BACK  = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_EXTRACT      = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PEEK_FRONT   = 3'd4;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PEEK_BACK    = 3'd5;

   typedef struct packed {
      logic append_ok;
      logic shift_all;
      logic shift_hit;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== src/bdq_cell.sv =====
// One storage cell of the deque chain: holds one entry, compares it with
// the search key and takes its right neighbor's entry on a shift. Uses bdq_pkg.
`default_nettype none
module bdq_cell
   import bdq_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 7
) (
   input  wire logic                   clock,
   input  wire cell_ctl_type           ctl,
   input  wire logic [COUNT_WIDTH-1:0] count,
   input  wire logic [VALUE_WIDTH-1:0] key,
   input  wire logic [VALUE_WIDTH-1:0] next_value,
   input  wire logic                   hit_incl,
   output logic      [VALUE_WIDTH-1:0] value,
   output logic                        match,
   output logic      [VALUE_WIDTH-1:0] tail_term
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic                   occupied;
   logic                   is_last;
   logic                   is_free;

   assign occupied = count > COUNT_WIDTH'(INDEX);
   assign is_last  = count == COUNT_WIDTH'(INDEX + 1);
   assign is_free  = count == COUNT_WIDTH'(INDEX);

   always_comb begin
      value_in = value_ff;
      if (ctl.append_ok && is_free) begin
         value_in = key;
      end else if (ctl.shift_all || (ctl.shift_hit && hit_incl)) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign match     = occupied && (value_ff == key);
   assign tail_term = is_last ? value_ff : '0;

endmodule
`default_nettype wire

// ===== src/bdq_prefix.sv =====
// Log-depth prefix OR over the cell match flags: bit i is set when any cell
// at or before position i matches. No package dependencies.
`default_nettype none
module bdq_prefix #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] match,
   output logic      [WIDTH-1:0] hit_incl
);

   localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] level_bits [0:LEVELS];

   assign level_bits[0] = match;

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < WIDTH; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign level_bits[l+1][i] = level_bits[l][i] | level_bits[l][i - (1 << l)];
         end else begin : g_pass
            assign level_bits[l+1][i] = level_bits[l][i];
         end
      end
   end

   assign hit_incl = level_bits[LEVELS];

endmodule
`default_nettype wire

// ===== src/bounded_deque_with_extract.sv =====
// Top level of the bounded deque with extract: cell chain, prefix unit,
// count and limit registers, result register. Uses bdq_pkg, bdq_cell, bdq_prefix.
//
//   channel  | ports                                        | direction
//   request  | req_valid, req_stall, req_func, req_item_value | in
//   response | rsp_valid, rsp_stall, rsp_result_value,       | out
//            |   rsp_success, rsp_entry_count               |
//   config   | csr_write_enable, csr_write_data             | in
//
// One request per cycle: every cell compares and shifts in the accept cycle,
// and the response is registered for the next cycle. Extract hit search runs
// through a log2(CAPACITY)-level prefix OR. Synchronous reset empties the
// deque and clears the limit; cell contents are not reset. A stalled
// response holds and stalls the request side only while it waits.
`default_nettype none
module bounded_deque_with_extract
   import bdq_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [FUNC_WIDTH-1:0]  req_func,
   input  wire logic [DATA_WIDTH-1:0]  req_item_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [DATA_WIDTH-1:0]  rsp_result_value,
   output logic                        rsp_success,
   output logic      [LIMIT_WIDTH-1:0] rsp_entry_count,
   input  wire logic                   csr_write_enable,
   input  wire logic [LIMIT_WIDTH-1:0] csr_write_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [LIMIT_WIDTH-1:0] entry_limit_ff;
   logic                   rsp_valid_ff;
   logic [DATA_WIDTH-1:0]  rsp_value_ff;
   logic                   rsp_success_ff;
   logic [LIMIT_WIDTH-1:0] rsp_count_ff;

   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   found;
   logic [VALUE_WIDTH-1:0] key;
   logic [VALUE_WIDTH-1:0] tail_value;
   logic [VALUE_WIDTH-1:0] result_value;
   logic                   result_ok;
   cell_ctl_type           ctl;

   logic [VALUE_WIDTH-1:0] cell_value [0:CAPACITY-1];
   logic [VALUE_WIDTH-1:0] tail_term  [0:CAPACITY-1];
   logic [CAPACITY-1:0]    match;
   logic [CAPACITY-1:0]    hit_incl;

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign key       = VALUE_WIDTH'(req_item_value);

   assign empty = count_ff == '0;
   assign full  = (count_ff == CW'(CAPACITY)) ||
                  ((entry_limit_ff != '0) && (LW'(count_ff) >= LW'(entry_limit_ff)));
   assign found = hit_incl[CAPACITY-1];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] next_value;
      if (i == CAPACITY - 1) begin : g_end
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end
      bdq_cell #(
         .INDEX      (i),
         .VALUE_WIDTH(VALUE_WIDTH),
         .COUNT_WIDTH(CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .key       (key),
         .next_value(next_value),
         .hit_incl  (hit_incl[i]),
         .value     (cell_value[i]),
         .match     (match[i]),
         .tail_term (tail_term[i])
      );
   end

   bdq_prefix #(.WIDTH(CAPACITY)) u_prefix (
      .match   (match),
      .hit_incl(hit_incl)
   );

   always_comb begin
      tail_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_value = tail_value | tail_term[i];
      end
   end

   always_comb begin
      ctl          = '0;
      count_in     = count_ff;
      result_value = '0;
      result_ok    = 1'b0;
      case (req_func)
         FUNC_APPEND: begin
            result_ok     = !full;
            result_value  = key;
            ctl.append_ok = accept && !full;
            if (!full) count_in = count_ff + CW'(1);
         end
         FUNC_REMOVE_FRONT: begin
            result_ok     = !empty;
            result_value  = cell_value[0];
            ctl.shift_all = accept && !empty;
            if (!empty) count_in = count_ff - CW'(1);
         end
         FUNC_REMOVE_BACK: begin
            result_ok    = !empty;
            result_value = tail_value;
            if (!empty) count_in = count_ff - CW'(1);
         end
         FUNC_EXTRACT: begin
            result_ok     = found;
            result_value  = key;
            ctl.shift_hit = accept && found;
            if (found) count_in = count_ff - CW'(1);
         end
         FUNC_PEEK_FRONT: begin
            result_ok    = !empty;
            result_value = cell_value[0];
         end
         FUNC_PEEK_BACK: begin
            result_ok    = !empty;
            result_value = tail_value;
         end
         default: begin
            result_ok = 1'b0;
         end
      endcase
      if (!result_ok) result_value = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         entry_limit_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) entry_limit_ff <= csr_write_data;
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff   <= DATA_WIDTH'(result_value);
         rsp_success_ff <= result_ok;
         rsp_count_ff   <= LIMIT_WIDTH'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule
`default_nettype wire

// ===== src/bdq_checker.sv =====
// Port-level checks for bounded_deque_with_extract and the bind that
// attaches them. Uses bdq_pkg.
`default_nettype none
module bdq_checker
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [DATA_WIDTH-1:0]  rsp_result_value,
   input wire logic                   rsp_success,
   input wire logic [LIMIT_WIDTH-1:0] rsp_entry_count
);

   logic [LIMIT_WIDTH-1:0] last_count_ff;
   logic [LIMIT_WIDTH-1:0] count_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_count_ff <= rsp_entry_count;
      end
   end

   assign count_step = rsp_entry_count - last_count_ff;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) &&
         $stable(rsp_success) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_result_value == '0)
      else $error("failed request returned a nonzero value");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_step == LIMIT_WIDTH'(0) || count_step == LIMIT_WIDTH'(1) ||
         count_step == '1)
      else $error("entry count moved by more than one");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && CAPACITY < 128 |-> int'(rsp_entry_count) <= CAPACITY)
      else $error("entry count above capacity");

endmodule

bind bounded_deque_with_extract bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_value(rsp_result_value),
   .rsp_success     (rsp_success),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire
